FILE: hdl/tdm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tdm_pkg;

	localparam int MAX_KEYS   = 64;
	localparam int NUM_BARS   = 9;
	localparam int BAR_W      = 4;
	localparam int LEVEL_W    = 15;
	localparam int LEVEL_SHIFT = 5;
	localparam int PART_W     = LEVEL_W - LEVEL_SHIFT;
	localparam int WHEEL_W    = 7;
	localparam int AMP_W      = 16;
	localparam int CAND_W     = 8;
	localparam int NUM_CAND   = 4;

	localparam logic [CAND_W-1:0] FOLD_LOW  = 8'd12;
	localparam logic [CAND_W-1:0] FOLD_HIGH = 8'd91;
	localparam logic [CAND_W-1:0] OCTAVE    = 8'd12;
	localparam logic [CAND_W-1:0] TWO_OCT   = 8'd24;
	// above this a single octave step down still lands past the top
	localparam logic [CAND_W-1:0] FOLD_TWICE = 8'd103;

	typedef enum logic [1:0] {
		KIND_KEY  = 2'd0,
		KIND_BAR  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef struct packed {
		logic             load;     // latch wheel, clear accumulator
		logic             key_wr;
		logic             bar_wr;
		logic             issue;    // push one drawbar into the datapath
		logic [BAR_W-1:0] bar_idx;
	} cmd_t;

	function automatic logic [5:0] bar_offset(input logic [BAR_W-1:0] idx);
		logic [5:0] off;
		case (idx)
			4'd0: off = 6'd0;
			4'd1: off = 6'd19;
			4'd2: off = 6'd12;
			4'd3: off = 6'd24;
			4'd4: off = 6'd31;
			4'd5: off = 6'd36;
			4'd6: off = 6'd40;
			4'd7: off = 6'd43;
			4'd8: off = 6'd48;
			default: off = 6'd0;
		endcase
		return off;
	endfunction

	// Fold into FOLD_LOW..FOLD_HIGH; valid for every sum key + offset can reach.
	function automatic logic [CAND_W-1:0] fold_wheel(input logic [CAND_W-1:0] v);
		logic [CAND_W-1:0] r;
		if (v < FOLD_LOW) begin
			r = v + OCTAVE;
		end else if (v > FOLD_TWICE) begin
			r = v - TWO_OCT;
		end else if (v > FOLD_HIGH) begin
			r = v - OCTAVE;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/tdm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tdm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    kind,
	output tdm_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import tdm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [BAR_W-1:0] bar_q;
	logic             busy_q;
	logic             done_q;
	logic             accept;

	assign accept = start && !busy_q;

	always_comb begin
		cmd.load    = accept && (kind == KIND_READ);
		cmd.key_wr  = accept && (kind == KIND_KEY);
		cmd.bar_wr  = accept && (kind == KIND_BAR);
		cmd.issue   = (state_q == ST_RUN);
		cmd.bar_idx = bar_q;
	end

	assign busy = busy_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bar_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						bar_q   <= '0;
						busy_q  <= 1'b1;
					end
				end
				ST_RUN: begin
					if (bar_q == BAR_W'(NUM_BARS - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						bar_q <= bar_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					// last drawbar lands in the accumulator at this edge
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/tdm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module tdm_datapath #(
	parameter int NUM_KEYS = 61
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire tdm_pkg::cmd_t             cmd,
	input  wire logic [5:0]                key_number,
	input  wire logic                      pressed,
	input  wire logic [3:0]                drawbar_number,
	input  wire logic [14:0]               drawbar_level,
	input  wire logic [6:0]                wheel_number,
	output logic [6:0]                     wheel_out,
	output logic [15:0]                    amplitude
);
	import tdm_pkg::*;

	logic [NUM_KEYS-1:0]  key_down_q;
	logic [LEVEL_W-1:0]   bar_lvl_q [NUM_BARS];
	logic [WHEEL_W-1:0]   wheel_q;
	logic [AMP_W-1:0]     acc_q;

	logic [NUM_CAND-1:0]  hit_s1;
	logic [PART_W-1:0]    part_s1;
	logic                 vld_s1;

	logic [MAX_KEYS-1:0]  keys64;
	logic [CAND_W-1:0]    cand   [NUM_CAND];
	logic [NUM_CAND-1:0]  hit;
	logic [CAND_W-1:0]    off8;
	logic [CAND_W-1:0]    wheel8;
	logic [CAND_W-1:0]    kidx   [NUM_CAND];
	logic [2:0]           hit_cnt;
	logic [PART_W+2:0]    prod;
	logic                 key_ok;

	assign keys64 = MAX_KEYS'(key_down_q);
	assign off8   = CAND_W'(bar_offset(cmd.bar_idx));
	assign wheel8 = CAND_W'(wheel_q);
	assign key_ok = (7'(key_number) < 7'(NUM_KEYS));

	// Only these four sums can fold onto the wheel being read.
	always_comb begin
		cand[0] = wheel8 - OCTAVE;
		cand[1] = wheel8;
		cand[2] = wheel8 + OCTAVE;
		cand[3] = wheel8 + TWO_OCT;
		for (int j = 0; j < NUM_CAND; j++) begin
			kidx[j] = cand[j] - off8;
			hit[j]  = (fold_wheel(cand[j]) == wheel8) && (cand[j] >= off8)
				&& (kidx[j] < CAND_W'(NUM_KEYS)) && keys64[kidx[j][5:0]];
		end
		// a wheel below one octave has no candidate an octave lower
		if (wheel8 < OCTAVE) begin
			hit[0] = 1'b0;
		end
	end

	assign hit_cnt = 3'(hit_s1[0]) + 3'(hit_s1[1]) + 3'(hit_s1[2]) + 3'(hit_s1[3]);
	assign prod    = hit_cnt * part_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_down_q <= '0;
			for (int b = 0; b < NUM_BARS; b++) begin
				bar_lvl_q[b] <= '0;
			end
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.key_wr && key_ok) begin
				for (int k = 0; k < NUM_KEYS; k++) begin
					if (key_number == 6'(k)) begin
						key_down_q[k] <= pressed;
					end
				end
			end
			if (cmd.bar_wr) begin
				for (int b = 0; b < NUM_BARS; b++) begin
					if (drawbar_number == BAR_W'(b)) begin
						bar_lvl_q[b] <= drawbar_level;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s1  <= hit;
		part_s1 <= bar_lvl_q[cmd.bar_idx][LEVEL_W-1:LEVEL_SHIFT];
		if (cmd.load) begin
			wheel_q <= wheel_number;
			acc_q   <= '0;
		end else if (vld_s1) begin
			acc_q <= acc_q + AMP_W'(prod);
		end
	end

	assign wheel_out = wheel_q;
	assign amplitude = acc_q;

endmodule

`default_nettype wire

FILE: hdl/tonewheel_drawbar_mixer.sv
`timescale 1ns / 1ps
`default_nettype none

// Tonewheel drawbar mixer: keeps a pressed bit for each manual key and a
// level for each of the nine drawbars, and sums drawbar levels onto a wheel.
// Command channel: a transaction is taken at the rising edge where start is
// high and busy is low; kind selects key event, drawbar set or wheel read,
// and the other input ports carry the fields for that kind.
// Key events and drawbar sets complete at the accepting edge, give no
// result and leave busy low, so one can be taken every cycle.
// A read raises busy and walks the drawbars one per cycle: the controller
// issues each of the nine drawbars in turn, then a drain state empties the
// candidate-match register, then done pulses for one cycle with wheel_out and
// amplitude. Busy falls with the result; until then no transaction is taken,
// and the drawbar walk through the shared match/multiply-add unit sets the
// read rate. A new transaction may be taken in the done cycle.
// Result channel: done marks the single cycle in which the result holds;
// the receiver has no way to stall it and must take it then.
// Reset (arst_n low) releases all keys, zeroes all drawbar levels and
// returns the controller to idle with done and busy low.
module tonewheel_drawbar_mixer #(
	parameter int NUM_KEYS = 61
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  kind,
	input  wire logic [5:0]  key_number,
	input  wire logic        pressed,
	input  wire logic [3:0]  drawbar_number,
	input  wire logic [14:0] drawbar_level,
	input  wire logic [6:0]  wheel_number,
	output logic             done,
	output logic [6:0]       wheel_out,
	output logic [15:0]      amplitude
);
	import tdm_pkg::*;

	cmd_t cmd;

	// Controller: decode the accepted transaction, sequence the drawbar walk.
	tdm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Datapath: key and drawbar state, candidate match, accumulate.
	tdm_datapath #(
		.NUM_KEYS (NUM_KEYS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.key_number     (key_number),
		.pressed        (pressed),
		.drawbar_number (drawbar_number),
		.drawbar_level  (drawbar_level),
		.wheel_number   (wheel_number),
		.wheel_out      (wheel_out),
		.amplitude      (amplitude)
	);

endmodule

`default_nettype wire

FILE: test/tdm_checker.sv
`timescale 1ns / 1ps

module tdm_checker #(
	parameter int NUM_KEYS = 61
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [1:0]  kind,
	input  wire logic [5:0]  key_number,
	input  wire logic        pressed,
	input  wire logic [3:0]  drawbar_number,
	input  wire logic [14:0] drawbar_level,
	input  wire logic [6:0]  wheel_number,
	input  wire logic        done,
	input  wire logic [6:0]  wheel_out,
	input  wire logic [15:0] amplitude,
	output int               mismatches,
	output int               reads_due
);
	import tdm_pkg::*;

	typedef struct {
		logic [WHEEL_W-1:0] wheel;
		logic [AMP_W-1:0]   amp;
	} wheel_read_t;

	// interval of each drawbar above the played key, in semitones
	localparam int BAR_STEP [NUM_BARS] = '{0, 19, 12, 24, 31, 36, 40, 43, 48};
	localparam int MAX_PRINTS = 20;

	logic [63:0]        keys_held;
	logic [LEVEL_W-1:0] bar_level [NUM_BARS];
	wheel_read_t        wheel_reads_q[$];
	wheel_read_t        oldest;
	int                 fail_cnt = 0;

	assign mismatches = fail_cnt;

	function automatic int fold_to_manual(input int v);
		while (v < int'(FOLD_LOW))
			v += int'(OCTAVE);
		while (v > int'(FOLD_HIGH))
			v -= int'(OCTAVE);
		return v;
	endfunction

	// sum of scaled drawbar levels over every held key that lands on wheel w
	function automatic logic [AMP_W-1:0] wheel_amplitude(input logic [WHEEL_W-1:0] w);
		logic [AMP_W-1:0]   acc;
		logic [LEVEL_W-1:0] part;
		acc = '0;
		for (int d = 0; d < NUM_BARS; d++) begin
			part = bar_level[d] >> LEVEL_SHIFT;
			for (int k = 0; k < NUM_KEYS; k++) begin
				if (keys_held[k] && fold_to_manual(k + BAR_STEP[d]) == int'(w))
					acc += AMP_W'(part);
			end
		end
		return acc;
	endfunction

	task automatic report_mismatch(input string what);
		if (fail_cnt < MAX_PRINTS)
			$display("%0t ns: mismatch: %s", $time, what);
		fail_cnt++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_held = '0;
			for (int d = 0; d < NUM_BARS; d++)
				bar_level[d] = '0;
			wheel_reads_q.delete();
			reads_due <= 0;
		end else begin
			// check the result first, a new read may be taken in the same cycle
			if (done) begin
				if (wheel_reads_q.size() == 0) begin
					report_mismatch($sformatf("result with none due, wheel %0d amplitude %0d",
						wheel_out, amplitude));
				end else begin
					oldest = wheel_reads_q.pop_front();
					if (wheel_out !== oldest.wheel)
						report_mismatch($sformatf("wheel_out %0d, want %0d",
							wheel_out, oldest.wheel));
					if (amplitude !== oldest.amp)
						report_mismatch($sformatf("amplitude %0d for wheel %0d, want %0d",
							amplitude, oldest.wheel, oldest.amp));
				end
			end
			if (start && !busy) begin
				case (kind_t'(kind))
					KIND_KEY: begin
						if (key_number < NUM_KEYS)
							keys_held[key_number] = pressed;
					end
					KIND_BAR: begin
						if (drawbar_number < NUM_BARS)
							bar_level[drawbar_number] = drawbar_level;
					end
					KIND_READ: begin
						wheel_reads_q.push_back('{wheel_number, wheel_amplitude(wheel_number)});
					end
					default: begin
					end
				endcase
			end
			reads_due <= wheel_reads_q.size();
		end
	end

endmodule

FILE: test/tb_tonewheel_drawbar_mixer.sv
`timescale 1ns / 1ps

// Drives key events, drawbar sets and wheel reads into the mixer; the checker
// beside the block predicts every read and compares it.
module tb_tonewheel_drawbar_mixer;
	import tdm_pkg::*;

	localparam int KEY_COUNT    = 61;
	localparam int RANDOM_ITEMS = 1350;
	// worst case is roughly 1400 reads plus long idle runs
	localparam int CYCLE_LIMIT  = 400000;
	// idle time at the end, more than one read needs to finish
	localparam int TAIL_CYCLES  = 20;
	// sender idle chance per cycle, one entry per random phase
	localparam int PHASE_IDLE [4] = '{0, 79, 0, 25};

	typedef struct packed {
		kind_t        kind;
		logic [5:0]   key;
		logic         pressed;
		logic [3:0]   bar;
		logic [14:0]  level;
		logic [6:0]   wheel;
	} mixer_cmd_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	kind_t       kind = KIND_KEY;
	logic [5:0]  key_number = '0;
	logic        pressed = 1'b0;
	logic [3:0]  drawbar_number = '0;
	logic [14:0] drawbar_level = '0;
	logic [6:0]  wheel_number = '0;
	logic        busy;
	logic        done;
	logic [6:0]  wheel_out;
	logic [15:0] amplitude;
	int          mismatches;
	int          reads_due;
	int          cycle_cnt = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tonewheel_drawbar_mixer #(
		.NUM_KEYS(KEY_COUNT)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.key_number     (key_number),
		.pressed        (pressed),
		.drawbar_number (drawbar_number),
		.drawbar_level  (drawbar_level),
		.wheel_number   (wheel_number),
		.done           (done),
		.wheel_out      (wheel_out),
		.amplitude      (amplitude)
	);

	tdm_checker #(
		.NUM_KEYS(KEY_COUNT)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.key_number     (key_number),
		.pressed        (pressed),
		.drawbar_number (drawbar_number),
		.drawbar_level  (drawbar_level),
		.wheel_number   (wheel_number),
		.done           (done),
		.wheel_out      (wheel_out),
		.amplitude      (amplitude),
		.mismatches     (mismatches),
		.reads_due      (reads_due)
	);

	// hard stop in case the block hangs with busy high or never answers
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic mixer_cmd_t make_cmd(input kind_t k, input int key, input bit prs,
			input int bar, input int level, input int wheel);
		mixer_cmd_t c;
		c.kind    = k;
		c.key     = 6'(key);
		c.pressed = prs;
		c.bar     = 4'(bar);
		c.level   = 15'(level);
		c.wheel   = 7'(wheel);
		return c;
	endfunction

	// Fields the kind does not use still carry random values, so every bit
	// of every port toggles. Most transactions stay in range; a few aim past
	// the key, drawbar or wheel range, and a few use the unused kind.
	function automatic mixer_cmd_t make_random_cmd();
		mixer_cmd_t c;
		int         pick;
		c = make_cmd(KIND_KEY, $urandom_range(63), $urandom_range(1), $urandom_range(15),
			$urandom_range(32767), $urandom_range(127));
		pick = $urandom_range(99);
		if (pick < 40) begin
			c.kind    = KIND_KEY;
			c.pressed = ($urandom_range(99) < 60);
			if ($urandom_range(9) != 0)
				c.key = 6'($urandom_range(KEY_COUNT - 1));
		end else if (pick < 62) begin
			c.kind = KIND_BAR;
			if ($urandom_range(9) != 0)
				c.bar = 4'($urandom_range(NUM_BARS - 1));
			case ($urandom_range(7))
				0: c.level = '0;
				1: c.level = '1;
				default: begin
				end
			endcase
		end else if (pick < 95) begin
			c.kind = KIND_READ;
			if ($urandom_range(7) != 0)
				c.wheel = 7'($urandom_range(91, 12));
		end else begin
			c.kind = KIND_NONE;
		end
		return c;
	endfunction

	// only transactions that change state or read count toward the total
	function automatic bit has_effect(input mixer_cmd_t c);
		case (c.kind)
			KIND_KEY:  return c.key < KEY_COUNT;
			KIND_BAR:  return c.bar < NUM_BARS;
			KIND_READ: return 1'b1;
			default:   return 1'b0;
		endcase
	endfunction

	// Hold start low for random idle cycles, then present the transaction
	// and keep it up until the edge where busy is low takes it.
	task automatic send_cmd(input mixer_cmd_t c, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			kind  <= kind_t'($urandom_range(3));
			@(posedge clk);
		end
		start          <= 1'b1;
		kind           <= c.kind;
		key_number     <= c.key;
		pressed        <= c.pressed;
		drawbar_number <= c.bar;
		drawbar_level  <= c.level;
		wheel_number   <= c.wheel;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Drop start and hold off until every pending read has come back.
	task automatic drain_reads();
		start <= 1'b0;
		@(posedge clk);
		while (reads_due != 0)
			@(posedge clk);
	endtask

	initial begin
		mixer_cmd_t c;
		int         pct;
		int         n;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset: in range, below and above the folded span.
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 12), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 127), 0);
		// Full levels on the lowest and highest drawbar; drawbars past the
		// last one must be dropped.
		send_cmd(make_cmd(KIND_BAR, 0, 0, 0, 32767, 0), 0);
		send_cmd(make_cmd(KIND_BAR, 0, 0, 8, 32767, 0), 0);
		send_cmd(make_cmd(KIND_BAR, 0, 0, 9, 1000, 0), 0);
		send_cmd(make_cmd(KIND_BAR, 0, 0, 15, 32767, 0), 0);
		// Lowest and highest key, then keys past the manual that are dropped.
		send_cmd(make_cmd(KIND_KEY, 0, 1, 0, 0, 0), 0);
		send_cmd(make_cmd(KIND_KEY, 60, 1, 0, 0, 0), 0);
		send_cmd(make_cmd(KIND_KEY, 61, 1, 0, 0, 0), 0);
		send_cmd(make_cmd(KIND_KEY, 63, 1, 15, 32767, 127), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 12), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 48), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 84), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 91), 0);
		// Unused kind with every field at its top.
		send_cmd(make_cmd(KIND_NONE, 63, 1, 15, 32767, 127), 0);
		// A level under one step of the shift contributes nothing.
		send_cmd(make_cmd(KIND_BAR, 0, 0, 4, 31, 0), 0);
		send_cmd(make_cmd(KIND_BAR, 0, 0, 2, 32, 0), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 24), 0);
		send_cmd(make_cmd(KIND_BAR, 0, 0, 1, 32767, 0), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 79), 0);
		send_cmd(make_cmd(KIND_KEY, 0, 0, 0, 0, 0), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 12), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 11), 0);
		send_cmd(make_cmd(KIND_READ, 0, 0, 0, 0, 92), 0);
		drain_reads();

		// Random part in four idle phases, each ending with a full drain.
		for (int phase = 0; phase < 4; phase++) begin
			n = 0;
			while (n < RANDOM_ITEMS / 4) begin
				c   = make_random_cmd();
				// short back-to-back bursts inside every phase
				pct = ((n % 50) < 8) ? 0 : PHASE_IDLE[phase];
				send_cmd(c, pct);
				if (has_effect(c))
					n++;
			end
			drain_reads();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && reads_due == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
